// ===== hdl/upqh_pkg.sv =====
`default_nettype none

package upqh_pkg;

  // default sizing
  localparam int CAPACITY_DEF  = 16;
  localparam int KEY_WIDTH_DEF = 32;

  // fixed port widths
  localparam int FUNC_W     = 2;
  localparam int HANDLE_W   = 4;
  localparam int IN_KEY_W   = 32;
  localparam int OUT_KEY_W  = 32;
  localparam int STATUS_W   = 2;

  // operation codes
  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_DELMAX = 2'd1,
    FN_CHANGE = 2'd2,
    FN_DELETE = 2'd3
  } func_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_BAD_HANDLE = 2'd3
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic    load;        // latch the input word, clear the result
    logic    idx_clr;     // restart the slot counter
    logic    idx_inc;     // advance the slot counter
    logic    best_clr;    // forget the running maximum
    logic    scan_rd;     // read key and rank at the counter for the max scan
    logic    sweep_rd;    // read rank at the counter for the rank sweep
    logic    rank_rd_h;   // read rank at the handle
    logic    ins_commit;  // store key in the free slot at the counter
    logic    chg_commit;  // overwrite key at the handle
    logic    max_take;    // free the best slot, report it
    logic    del_take;    // free the slot at the handle
    logic    fail;        // report an error status
    status_t fail_code;
    logic    out_load;    // move the result into the output register
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    func_t func;
    logic  free_hit;
    logic  idx_last;
    logic  best_found;
    logic  handle_ok;
    logic  out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/upqh_dp.sv =====
`default_nettype none

module upqh_dp #(
  parameter int CAPACITY  = upqh_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = upqh_pkg::KEY_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [upqh_pkg::FUNC_W-1:0]     in_func,
  input  logic [upqh_pkg::HANDLE_W-1:0]   in_handle,
  input  logic [upqh_pkg::IN_KEY_W-1:0]   in_key,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [upqh_pkg::OUT_KEY_W-1:0]  out_result_key,
  output logic [upqh_pkg::HANDLE_W-1:0]   out_result_handle,
  output logic [upqh_pkg::STATUS_W-1:0]   out_status,
  output logic                            out_now_empty,
  input  upqh_pkg::dp_cmd_t               cmd,
  output upqh_pkg::dp_stat_t              st
);
  import upqh_pkg::*;

  localparam int IDXW = $clog2(CAPACITY);
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int HW   = (IDXW + 1 > HANDLE_W) ? IDXW + 1 : HANDLE_W;

  // latched input word
  func_t                 func_r;
  logic [HANDLE_W-1:0]   handle_r;
  logic [KEY_WIDTH-1:0]  key_r;

  // slot counter and read pipeline
  logic [IDXW-1:0]       idx_r;
  logic [IDXW-1:0]       pend_idx_r;
  logic                  pend_max_r;
  logic                  pend_sw_r;

  // occupancy
  logic [CAPACITY-1:0]   valid_r;
  logic [CNTW-1:0]       count_r;

  // running maximum
  logic                  best_found_r;
  logic [IDXW-1:0]       best_idx_r;
  logic [KEY_WIDTH-1:0]  best_key_r;
  logic [IDXW-1:0]       best_rank_r;
  logic [IDXW-1:0]       rm_rank_r;

  // result under construction
  logic [KEY_WIDTH-1:0]  res_key_r;
  logic [IDXW-1:0]       res_handle_r;
  status_t               res_status_r;

  // output register
  logic                  out_valid_r;
  logic [OUT_KEY_W-1:0]  out_key_r;
  logic [HANDLE_W-1:0]   out_handle_r;
  status_t               out_status_r;
  logic                  out_empty_r;

  // slot memories
  logic [KEY_WIDTH-1:0]  key_mem_r  [CAPACITY];
  logic [IDXW-1:0]       rank_mem_r [CAPACITY];
  logic [KEY_WIDTH-1:0]  key_rd_r;
  logic [IDXW-1:0]       rank_rd_r;

  logic [HW-1:0]         handle_ext;
  logic [IDXW-1:0]       handle_idx;
  logic                  handle_in_range;
  logic                  handle_ok;
  logic                  cand_valid;
  logic                  cand_better;
  logic                  sw_dec;
  logic                  key_we;
  logic [IDXW-1:0]       key_wa;
  logic                  rank_we;
  logic [IDXW-1:0]       rank_wa;
  logic [IDXW-1:0]       rank_wd;
  logic [IDXW-1:0]       rank_ra;

  // handle decode
  assign handle_ext      = HW'(handle_r);
  assign handle_idx      = handle_ext[IDXW-1:0];
  assign handle_in_range = handle_ext < HW'(CAPACITY);
  assign handle_ok       = handle_in_range ? valid_r[handle_idx] : 1'b0;

  // max scan compare, ties go to the higher rank
  assign cand_valid  = pend_max_r && valid_r[pend_idx_r];
  assign cand_better = !best_found_r || (key_rd_r > best_key_r) ||
                       ((key_rd_r == best_key_r) && (rank_rd_r > best_rank_r));

  // rank sweep after a removal
  assign sw_dec = pend_sw_r && valid_r[pend_idx_r] && (rank_rd_r > rm_rank_r);

  // memory port control
  assign key_we  = cmd.ins_commit || cmd.chg_commit;
  assign key_wa  = cmd.chg_commit ? handle_idx : idx_r;
  assign rank_we = cmd.ins_commit || sw_dec;
  assign rank_wa = cmd.ins_commit ? idx_r : pend_idx_r;
  assign rank_wd = cmd.ins_commit ? IDXW'(count_r) : (rank_rd_r - IDXW'(1));
  assign rank_ra = cmd.rank_rd_h ? handle_idx : idx_r;

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem_r[key_wa] <= key_r;
    end
    if (rank_we) begin
      rank_mem_r[rank_wa] <= rank_wd;
    end
    key_rd_r  <= key_mem_r[idx_r];
    rank_rd_r <= rank_mem_r[rank_ra];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r        <= '0;
      pend_max_r   <= 1'b0;
      pend_sw_r    <= 1'b0;
      valid_r      <= '0;
      count_r      <= '0;
      best_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      pend_max_r <= cmd.scan_rd;
      pend_sw_r  <= cmd.sweep_rd;
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + IDXW'(1);
      end
      if (cmd.best_clr) begin
        best_found_r <= 1'b0;
      end else if (cand_valid && cand_better) begin
        best_found_r <= 1'b1;
      end
      if (cmd.ins_commit) begin
        valid_r[idx_r] <= 1'b1;
        count_r        <= count_r + CNTW'(1);
      end else if (cmd.max_take) begin
        valid_r[best_idx_r] <= 1'b0;
        count_r             <= count_r - CNTW'(1);
      end else if (cmd.del_take) begin
        valid_r[handle_idx] <= 1'b0;
        count_r             <= count_r - CNTW'(1);
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    pend_idx_r <= idx_r;
    if (cmd.load) begin
      func_r       <= func_t'(in_func);
      handle_r     <= in_handle;
      key_r        <= KEY_WIDTH'(in_key);
      res_key_r    <= '0;
      res_handle_r <= '0;
      res_status_r <= ST_OK;
    end
    if (cand_valid && cand_better) begin
      best_idx_r  <= pend_idx_r;
      best_key_r  <= key_rd_r;
      best_rank_r <= rank_rd_r;
    end
    if (cmd.ins_commit) begin
      res_handle_r <= idx_r;
    end
    if (cmd.fail) begin
      res_status_r <= cmd.fail_code;
    end
    if (cmd.max_take) begin
      res_key_r    <= best_key_r;
      res_handle_r <= best_idx_r;
      rm_rank_r    <= best_rank_r;
    end
    if (cmd.del_take) begin
      rm_rank_r <= rank_rd_r;
    end
    if (cmd.out_load) begin
      out_key_r    <= OUT_KEY_W'(res_key_r);
      out_handle_r <= HANDLE_W'(res_handle_r);
      out_status_r <= res_status_r;
      out_empty_r  <= (count_r == '0);
    end
  end

  // status to controller
  assign st.func       = func_r;
  assign st.free_hit   = !valid_r[idx_r];
  assign st.idx_last   = (idx_r == IDXW'(CAPACITY - 1));
  assign st.best_found = best_found_r;
  assign st.handle_ok  = handle_ok;
  assign st.out_free   = !out_valid_r || out_ready;

  // output ports
  assign out_valid         = out_valid_r;
  assign out_result_key    = out_key_r;
  assign out_result_handle = out_handle_r;
  assign out_status        = out_status_r;
  assign out_now_empty     = out_empty_r;

  // occupancy count tracks the valid bits
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(count_r))
    else $error("entry count out of step with valid bits");

  // insert only lands in a free slot
  a_insert_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_commit |-> !valid_r[idx_r])
    else $error("insert into occupied slot");

  // a removal by max needs a winner
  a_take_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.max_take |-> best_found_r)
    else $error("delete max without a candidate");

  // result never overwrites a word still waiting
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten");

endmodule

`default_nettype wire

// ===== hdl/upqh_ctrl.sv =====
`default_nettype none

module upqh_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic [upqh_pkg::FUNC_W-1:0]  in_func,
  output logic                         in_ready,
  output upqh_pkg::dp_cmd_t            cmd,
  input  upqh_pkg::dp_stat_t           st
);
  import upqh_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FREE,
    S_MAX,
    S_MAX_END,
    S_MAX_PICK,
    S_CHECK,
    S_RANK_WAIT,
    S_SWEEP,
    S_SWEEP_END,
    S_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   in_ready_r;

  // sequencing
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid && in_ready_r) begin
          cmd.load     = 1'b1;
          cmd.idx_clr  = 1'b1;
          cmd.best_clr = 1'b1;
          case (func_t'(in_func))
            FN_INSERT: state_nxt = S_FREE;
            FN_DELMAX: state_nxt = S_MAX;
            default:   state_nxt = S_CHECK;
          endcase
        end
      end
      // lowest free slot, one slot a cycle
      S_FREE: begin
        if (st.free_hit) begin
          cmd.ins_commit = 1'b1;
          state_nxt      = S_DONE;
        end else if (st.idx_last) begin
          cmd.fail      = 1'b1;
          cmd.fail_code = ST_FULL;
          state_nxt     = S_DONE;
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      // max scan, the compare acts on the read data in the cycle after the read
      S_MAX: begin
        cmd.scan_rd = 1'b1;
        cmd.idx_inc = 1'b1;
        if (st.idx_last) begin
          state_nxt = S_MAX_END;
        end
      end
      S_MAX_END: begin
        state_nxt = S_MAX_PICK;
      end
      S_MAX_PICK: begin
        if (st.best_found) begin
          cmd.max_take = 1'b1;
          cmd.idx_clr  = 1'b1;
          state_nxt    = S_SWEEP;
        end else begin
          cmd.fail      = 1'b1;
          cmd.fail_code = ST_EMPTY;
          state_nxt     = S_DONE;
        end
      end
      // change or delete by handle
      S_CHECK: begin
        if (!st.handle_ok) begin
          cmd.fail      = 1'b1;
          cmd.fail_code = ST_BAD_HANDLE;
          state_nxt     = S_DONE;
        end else if (st.func == FN_CHANGE) begin
          cmd.chg_commit = 1'b1;
          state_nxt      = S_DONE;
        end else begin
          cmd.rank_rd_h = 1'b1;
          state_nxt     = S_RANK_WAIT;
        end
      end
      S_RANK_WAIT: begin
        cmd.del_take = 1'b1;
        cmd.idx_clr  = 1'b1;
        state_nxt    = S_SWEEP;
      end
      // close the gap in the recency ranks
      S_SWEEP: begin
        cmd.sweep_rd = 1'b1;
        cmd.idx_inc  = 1'b1;
        if (st.idx_last) begin
          state_nxt = S_SWEEP_END;
        end
      end
      S_SWEEP_END: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state and ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_ready_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_ready_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = in_ready_r;

  // one word at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken twice in a row");

  // ready only while waiting for a word
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (state_r == S_IDLE))
    else $error("ready outside idle");

endmodule

`default_nettype wire

// ===== hdl/unordered_priority_queue_handles_core.sv =====
// Bounded priority queue with handles, CAPACITY slots of KEY_WIDTH-bit keys.
// Input channel (in_valid/in_ready): in_func selects insert, delete max,
// change key or delete handle; in_handle and in_key carry the operands.
// Result channel (out_valid/out_ready): exactly one word per input word,
// with the removed key, the slot allocated by insert or freed by delete
// max, a status code and whether the queue is now empty.
// One word is worked on at a time, paced by a slot counter that steps
// through the key and rank memories one slot per cycle. Work per word:
//   change, or any bad handle: one handle check, then the result
//   insert: a search from slot 0 up to the lowest free slot
//   delete max: a full scan then a rank sweep; only the scan when empty
//   delete handle: one rank read then a rank sweep
// in_ready rises at the same edge that loads the result into the output
// register. A result held by a stalled receiver does not block the next
// accept; the block only waits when that next result is ready to go out.
// Reset (rst_n low, synchronous) empties the queue at once; no clear pass.
`default_nettype none

module unordered_priority_queue_handles_core #(
  parameter int CAPACITY  = upqh_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = upqh_pkg::KEY_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [upqh_pkg::FUNC_W-1:0]     in_func,
  input  logic [upqh_pkg::HANDLE_W-1:0]   in_handle,
  input  logic [upqh_pkg::IN_KEY_W-1:0]   in_key,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [upqh_pkg::OUT_KEY_W-1:0]  out_result_key,
  output logic [upqh_pkg::HANDLE_W-1:0]   out_result_handle,
  output logic [upqh_pkg::STATUS_W-1:0]   out_status,
  output logic                            out_now_empty
);
  import upqh_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t st;

  // sequencer
  upqh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_ready (in_ready),
    .cmd      (cmd),
    .st       (st)
  );

  // slot storage and compare
  upqh_dp #(
    .CAPACITY  (CAPACITY),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_func           (in_func),
    .in_handle         (in_handle),
    .in_key            (in_key),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_key    (out_result_key),
    .out_result_handle (out_result_handle),
    .out_status        (out_status),
    .out_now_empty     (out_now_empty),
    .cmd               (cmd),
    .st                (st)
  );

endmodule

`default_nettype wire

// ===== sim/queue_result_checker.sv =====
`default_nettype none

module queue_result_checker #(
  parameter int SLOTS = upqh_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [upqh_pkg::FUNC_W-1:0]    in_func,
  input  logic [upqh_pkg::HANDLE_W-1:0]  in_handle,
  input  logic [upqh_pkg::IN_KEY_W-1:0]  in_key,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [upqh_pkg::OUT_KEY_W-1:0] out_result_key,
  input  logic [upqh_pkg::HANDLE_W-1:0]  out_result_handle,
  input  logic [upqh_pkg::STATUS_W-1:0]  out_status,
  input  logic                           out_now_empty,
  output int                             mismatch_count,
  output int                             results_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import upqh_pkg::*;

  typedef struct packed {
    logic [OUT_KEY_W-1:0] key;
    logic [HANDLE_W-1:0]  handle;
    status_t              status;
    logic                 now_empty;
  } queue_result_t;

  // shadow copy of the slot store
  logic [IN_KEY_W-1:0] slot_key  [SLOTS];
  bit                  slot_used [SLOTS];
  int unsigned         slot_rank [SLOTS];
  int unsigned         live_count;

  queue_result_t pending_results [$];
  int            errors;

  initial begin
    mismatch_count = 0;
    results_due    = 0;
    errors         = 0;
  end

  // free a slot and close the gap in the age ranks
  function automatic void free_slot(int s);
    int unsigned r;
    r = slot_rank[s];
    slot_used[s] = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if (slot_used[i] && slot_rank[i] > r) slot_rank[i]--;
    end
    if (live_count > 0) live_count--;
  endfunction

  // apply one operation to the shadow store and return its result word
  function automatic queue_result_t predict_op(func_t f, logic [HANDLE_W-1:0] h,
                                               logic [IN_KEY_W-1:0] k);
    queue_result_t r;
    int pick;
    r        = '0;
    r.status = ST_OK;
    pick     = -1;
    case (f)
      FN_INSERT: begin
        // lowest free slot
        for (int i = 0; i < SLOTS; i++) begin
          if (!slot_used[i] && pick < 0) pick = i;
        end
        if (pick < 0) begin
          r.status = ST_FULL;
        end else begin
          slot_key[pick]  = k;
          slot_used[pick] = 1'b1;
          slot_rank[pick] = live_count;
          live_count++;
          r.handle = HANDLE_W'(pick);
        end
      end
      FN_DELMAX: begin
        // largest key, newest entry on a tie
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_used[i] && (pick < 0 || slot_key[i] > slot_key[pick] ||
              (slot_key[i] == slot_key[pick] && slot_rank[i] > slot_rank[pick])))
            pick = i;
        end
        if (pick < 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.key    = slot_key[pick];
          r.handle = HANDLE_W'(pick);
          free_slot(pick);
        end
      end
      default: begin
        if (int'(h) >= SLOTS || !slot_used[h]) begin
          r.status = ST_BAD_HANDLE;
        end else if (f == FN_CHANGE) begin
          slot_key[h] = k;
        end else begin
          free_slot(int'(h));
        end
      end
    endcase
    r.now_empty = (live_count == 0);
    return r;
  endfunction

  // compare result words against predictions, then predict accepted words
  always @(posedge clk) begin
    queue_result_t got;
    queue_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_used[i] = 1'b0;
        slot_rank[i] = 0;
        slot_key[i]  = '0;
      end
      live_count = 0;
      pending_results.delete();
    end else begin
      if (out_valid && out_ready) begin
        got = '{out_result_key, out_result_handle, status_t'(out_status), out_now_empty};
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result word key %h handle %0d status %0d empty %b",
                     $realtime, got.key, got.handle, got.status, got.now_empty);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display({"%0t: result mismatch: expected key %h handle %0d status %0d ",
                        "empty %b, got key %h handle %0d status %0d empty %b"},
                       $realtime, want.key, want.handle, want.status, want.now_empty,
                       got.key, got.handle, got.status, got.now_empty);
          end
        end
      end
      if (in_valid && in_ready)
        pending_results.push_back(predict_op(func_t'(in_func), in_handle, in_key));
    end
    results_due    <= pending_results.size();
    mismatch_count <= errors;
  end

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import upqh_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 3 * CAPACITY_DEF + 10;
  localparam int RANDOM_WORDS = 1000;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [FUNC_W-1:0]    in_func = FN_INSERT;
  logic [HANDLE_W-1:0]  in_handle = '0;
  logic [IN_KEY_W-1:0]  in_key = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [OUT_KEY_W-1:0] out_result_key;
  logic [HANDLE_W-1:0]  out_result_handle;
  logic [STATUS_W-1:0]  out_status;
  logic                 out_now_empty;
  int                   mismatch_count;
  int                   results_due;

  unordered_priority_queue_handles_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_handle         (in_handle),
    .in_key            (in_key),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_key    (out_result_key),
    .out_result_handle (out_result_handle),
    .out_status        (out_status),
    .out_now_empty     (out_now_empty)
  );

  queue_result_checker result_check (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_handle         (in_handle),
    .in_key            (in_key),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_key    (out_result_key),
    .out_result_handle (out_result_handle),
    .out_status        (out_status),
    .out_now_empty     (out_now_empty),
    .mismatch_count    (mismatch_count),
    .results_due       (results_due)
  );

  // 4 ns clock
  initial begin
    forever #2 clk = ~clk;
  end

  // keys biased toward extremes and a tiny pool so ties happen
  function automatic logic [IN_KEY_W-1:0] draw_key();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return IN_KEY_W'($urandom_range(0, 3));
      default: return $urandom;
    endcase
  endfunction

  // offer one word after a random gap, return at the edge it is taken
  task automatic send_word(func_t f, logic [HANDLE_W-1:0] h, logic [IN_KEY_W-1:0] k,
                           bit calm);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_func   <= f;
    in_handle <= h;
    in_key    <= k;
    in_valid  <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold the sender off until every result word has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  // stimulus and verdict
  initial begin
    int    sent;
    int    mode;
    int    len;
    bit    paused;
    func_t f;
    sent   = 0;
    paused = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty, bad handles, extreme keys, ties, drain to empty
    send_word(FN_DELMAX, 4'd0,  '0,            1'b0);
    send_word(FN_CHANGE, 4'd3,  32'h1234_5678, 1'b0);
    send_word(FN_DELETE, 4'd15, '0,            1'b0);
    send_word(FN_INSERT, 4'd0,  '0,            1'b0);
    send_word(FN_INSERT, 4'd0,  '1,            1'b0);
    send_word(FN_INSERT, 4'd0,  '1,            1'b0);
    send_word(FN_INSERT, 4'd0,  '0,            1'b0);
    send_word(FN_DELMAX, 4'd0,  '0,            1'b0);
    send_word(FN_CHANGE, 4'd0,  32'hA5A5_5A5A, 1'b0);
    send_word(FN_CHANGE, 4'd2,  32'h0000_0001, 1'b0);
    send_word(FN_DELETE, 4'd1,  '0,            1'b0);
    send_word(FN_DELETE, 4'd1,  '0,            1'b0);
    send_word(FN_INSERT, 4'd0,  32'hA5A5_5A5A, 1'b0);
    send_word(FN_DELMAX, 4'd0,  '0,            1'b0);
    send_word(FN_DELMAX, 4'd0,  '0,            1'b0);
    send_word(FN_DELMAX, 4'd0,  '0,            1'b0);
    send_word(FN_DELMAX, 4'd0,  '0,            1'b0);
    send_word(FN_DELETE, 4'd0,  '0,            1'b0);

    // random bursts: fill, drain or churn
    while (sent < RANDOM_WORDS) begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(8, 24);
      for (int j = 0; j < len; j++) begin
        if (!paused && sent >= RANDOM_WORDS / 2) begin
          drain_results();
          paused = 1'b1;
        end
        case (mode)
          0:       f = ($urandom_range(0, 9) < 9) ? FN_INSERT : func_t'($urandom_range(1, 3));
          1:       f = ($urandom_range(0, 9) < 9) ? FN_DELMAX : func_t'($urandom_range(0, 3));
          default: f = func_t'($urandom_range(0, 3));
        endcase
        send_word(f, HANDLE_W'($urandom_range(0, 15)), draw_key(), ((sent / 80) % 4) == 2);
        sent++;
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // result side: random stalls, one long hold-off so the block backs up
  initial begin
    int hold;
    int taken;
    taken = 0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken == 300) begin
        out_ready <= 1'b0;
        repeat (200) @(posedge clk);
      end
      hold = (((taken / 100) % 4) == 1) ? 0 : $urandom_range(0, 6);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  // watchdog on cycles without any handshake
  initial begin
    int idle;
    idle = 0;
    while (idle < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
